// ===== rtl/bdel_pkg.sv =====
// Shared types and constants for the button debounce / event latch block.
// No dependencies; imported by every module of the block.
package bdel_pkg;

    // Pending event codes, two bits per channel
    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_RELEASED = 2'd2
    } t_event;

    localparam int TIME_W  = 32;
    localparam int DEB_W   = 16;
    localparam int COUNT_W = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index decoded from paddr[2] (registers at byte 0 and 4)
    localparam logic IDX_DEBOUNCE = 1'b0;
    localparam logic IDX_ACTIVE   = 1'b1;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd20;

    // What one lane reports to the merge stage
    typedef struct packed {
        logic                pressed;
        t_event              ev_code;
        logic [COUNT_W-1:0]  count;
    } t_lane_stat;

endpackage

// ===== rtl/bdel_if.sv =====
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on bdel_pkg for field widths.
interface bdel_in_if
    import bdel_pkg::*;
#(
    parameter int CHANNELS = 2
);
    localparam int SEL_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                valid;
    logic                ready;
    logic [CHANNELS-1:0] pin_levels;
    logic [TIME_W-1:0]   now_ms;
    logic [CHANNELS-1:0] event_read_mask;
    logic [SEL_W-1:0]    count_channel;

    modport source (output valid, pin_levels, now_ms, event_read_mask, count_channel,
                    input ready);
    modport sink   (input valid, pin_levels, now_ms, event_read_mask, count_channel,
                    output ready);
endinterface

interface bdel_out_if
    import bdel_pkg::*;
#(
    parameter int CHANNELS = 2
);
    logic                  valid;
    logic                  ready;
    logic [CHANNELS-1:0]   pressed_mask;
    logic [2*CHANNELS-1:0] event_codes;
    logic [COUNT_W-1:0]    press_count;

    modport source (output valid, pressed_mask, event_codes, press_count, input ready);
    modport sink   (input valid, pressed_mask, event_codes, press_count, output ready);
endinterface

// ===== rtl/bdel_lane.sv =====
// One debounce lane: five-state machine, press counter and pending event latch.
// Depends on bdel_pkg.
module bdel_lane
    import bdel_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_active,
    input  logic [TIME_W-1:0]  i_now,
    input  logic [DEB_W-1:0]   i_debounce_ms,
    input  logic               i_clear,
    output t_lane_stat         o_stat
);

    typedef enum logic [2:0] {
        S_IDLE        = 3'd0,
        S_DEB_PRESS   = 3'd1,
        S_DEB_RELEASE = 3'd2,
        S_PRESSED     = 3'd3,
        S_RELEASED    = 3'd4
    } t_dstate;

    t_dstate             r_state,   n_state;
    logic [TIME_W-1:0]   r_start,   n_start;
    logic                r_pressed, n_pressed;
    logic [COUNT_W-1:0]  r_count,   n_count;
    t_event              r_event,   n_event;
    logic                w_expired;

    // wrapping elapsed time
    assign w_expired = (i_now - r_start) >= {{(TIME_W-DEB_W){1'b0}}, i_debounce_ms};

    always_comb begin
        n_state   = r_state;
        n_start   = r_start;
        n_pressed = r_pressed;
        n_count   = r_count;
        n_event   = r_event;
        unique case (r_state)
            S_DEB_PRESS: begin
                if (w_expired) begin
                    n_pressed = 1'b1;
                    n_count   = r_count + COUNT_W'(1);
                    n_state   = S_PRESSED;
                    n_event   = EV_PRESSED;
                end else if (!i_active) begin
                    n_state = S_IDLE;
                end
            end
            S_DEB_RELEASE: begin
                if (w_expired) begin
                    n_pressed = 1'b0;
                    n_state   = S_RELEASED;
                    n_event   = EV_RELEASED;
                end else if (i_active) begin
                    n_state = S_IDLE;
                end
            end
            S_PRESSED: begin
                if (!i_active) n_state = S_IDLE;
            end
            S_RELEASED: begin
                if (i_active) n_state = S_IDLE;
            end
            default: begin
                n_start = i_now;
                n_state = i_active ? S_DEB_PRESS : S_DEB_RELEASE;
            end
        endcase
    end

    // result shows the event before this transfer's read clears it
    assign o_stat = '{pressed: n_pressed, ev_code: n_event, count: n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_start   <= '0;
            r_pressed <= 1'b0;
            r_count   <= '0;
            r_event   <= EV_NONE;
        end else if (i_step) begin
            r_state   <= n_state;
            r_start   <= n_start;
            r_pressed <= n_pressed;
            r_count   <= n_count;
            r_event   <= i_clear ? EV_NONE : n_event;
        end
    end

endmodule

// ===== rtl/bdel_merge.sv =====
// Merge stage: packs the lane reports into one result and holds it in the
// output register. Depends on bdel_pkg.
module bdel_merge
    import bdel_pkg::*;
#(
    parameter int CHANNELS = 2,
    parameter int SEL_W    = 1
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  t_lane_stat            i_stat [CHANNELS],
    input  logic [SEL_W-1:0]      i_sel,
    input  logic                  i_out_ready,
    output logic                  o_in_ready,
    output logic                  o_valid,
    output logic [CHANNELS-1:0]   o_pressed_mask,
    output logic [2*CHANNELS-1:0] o_event_codes,
    output logic [COUNT_W-1:0]    o_press_count
);

    logic                  r_valid;
    logic [CHANNELS-1:0]   r_pressed_mask, n_pressed_mask;
    logic [2*CHANNELS-1:0] r_event_codes,  n_event_codes;
    logic [COUNT_W-1:0]    r_press_count,  n_press_count;

    always_comb begin
        n_pressed_mask = '0;
        n_event_codes  = '0;
        n_press_count  = '0;   // selection beyond the channel count reads zero
        for (int c = 0; c < CHANNELS; c++) begin
            n_pressed_mask[c]       = i_stat[c].pressed;
            n_event_codes[2*c +: 2] = i_stat[c].ev_code;
            if (i_sel == SEL_W'(c)) begin
                n_press_count = i_stat[c].count;
            end
        end
    end

    assign o_in_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pressed_mask <= n_pressed_mask;
            r_event_codes  <= n_event_codes;
            r_press_count  <= n_press_count;
        end
    end

    assign o_valid        = r_valid;
    assign o_pressed_mask = r_pressed_mask;
    assign o_event_codes  = r_event_codes;
    assign o_press_count  = r_press_count;

endmodule

// ===== rtl/button_debounce_event_latch_core.sv =====
// Button debounce and event latch, top level: APB registers, one debounce
// lane per channel and the merge/output stage. Depends on bdel_pkg, bdel_if,
// bdel_lane and bdel_merge.
//
// Takes one sample transfer per clock and returns one result transfer per
// sample, in the following cycle through the output register; a new sample is taken
// while the previous result waits, as long as the output side takes results.
// Each channel has its own lane whose state machine steps on every accepted
// sample, so the rate is set only by the output handshake. Debounce is timed
// on the wrapping now_ms field against debounce_ms (APB byte 0), and pin
// polarity comes from active_level_mask (APB byte 4, bit set = active high).
// A pending event stays latched until a sample sets its event_read_mask bit;
// the result of that sample still shows it. Write registers only while idle.
module button_debounce_event_latch_core
    import bdel_pkg::*;
#(
    parameter int CHANNELS = 2
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    bdel_in_if.sink            i_in,
    bdel_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int SEL_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [DEB_W-1:0]    r_debounce_ms;
    logic [CHANNELS-1:0] r_active_mask;
    logic                w_cfg_wr;
    logic                w_in_ready;
    logic                w_accept;
    t_lane_stat          w_stat [CHANNELS];

    // APB registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RESET;
            r_active_mask <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                IDX_DEBOUNCE: r_debounce_ms <= pwdata[DEB_W-1:0];
                IDX_ACTIVE:   r_active_mask <= pwdata[CHANNELS-1:0];
                default:      r_debounce_ms <= r_debounce_ms;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            IDX_DEBOUNCE: prdata = PDATA_W'(r_debounce_ms);
            IDX_ACTIVE:   prdata = PDATA_W'(r_active_mask);
            default:      prdata = '0;
        endcase
    end

    assign w_accept   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        bdel_lane u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_step        (w_accept),
            .i_active      (i_in.pin_levels[c] == r_active_mask[c]),
            .i_now         (i_in.now_ms),
            .i_debounce_ms (r_debounce_ms),
            .i_clear       (i_in.event_read_mask[c]),
            .o_stat        (w_stat[c])
        );
    end

    bdel_merge #(
        .CHANNELS (CHANNELS),
        .SEL_W    (SEL_W)
    ) u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_accept),
        .i_stat         (w_stat),
        .i_sel          (i_in.count_channel),
        .i_out_ready    (o_out.ready),
        .o_in_ready     (w_in_ready),
        .o_valid        (o_out.valid),
        .o_pressed_mask (o_out.pressed_mask),
        .o_event_codes  (o_out.event_codes),
        .o_press_count  (o_out.press_count)
    );

endmodule

// ===== rtl/bdel_chk.sv =====
// Port-level checker for button_debounce_event_latch_core, attached by bind.
// Depends on bdel_pkg.
module bdel_chk
    import bdel_pkg::*;
#(
    parameter int CHANNELS = 2
)(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [CHANNELS-1:0]   i_pressed_mask,
    input logic [2*CHANNELS-1:0] i_event_codes,
    input logic [COUNT_W-1:0]    i_press_count
);

    logic w_bad_code;

    always_comb begin
        w_bad_code = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (i_event_codes[2*c +: 2] == 2'b11) w_bad_code = 1'b1;
        end
    end

    // every accepted sample shows up as a result next cycle
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted sample produced no result");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    a_no_bad_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !w_bad_code)
        else $error("event code 3 reported");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_pressed_mask) && $stable(i_event_codes)
             && $stable(i_press_count)))
        else $error("stalled result changed");

endmodule

bind button_debounce_event_latch_core bdel_chk #(.CHANNELS(CHANNELS)) u_bdel_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_pressed_mask (o_out.pressed_mask),
    .i_event_codes  (o_out.event_codes),
    .i_press_count  (o_out.press_count)
);

// ===== dv/bdel_checker.sv =====
// Result checker for button_debounce_event_latch_core: watches the sample, result and APB
// ports, predicts each result and compares it field by field.
// Depends on bdel_pkg.
module bdel_checker
    import bdel_pkg::*;
#(
    parameter int CHANNELS = 2,
    parameter int SEL_W    = 1
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [CHANNELS-1:0]   i_pin_levels,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic [CHANNELS-1:0]   i_event_read_mask,
    input  logic [SEL_W-1:0]      i_count_channel,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [CHANNELS-1:0]   i_pressed_mask,
    input  logic [2*CHANNELS-1:0] i_event_codes,
    input  logic [COUNT_W-1:0]    i_press_count,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [PADDR_W-1:0]    i_paddr,
    input  logic [PDATA_W-1:0]    i_pwdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef enum logic [2:0] {
        DB_IDLE,
        DB_WAIT_PRESS,
        DB_WAIT_RELEASE,
        DB_HELD,
        DB_LET_GO
    } t_db_state;

    typedef struct packed {
        logic [CHANNELS-1:0]   pressed;
        logic [2*CHANNELS-1:0] codes;
        logic [COUNT_W-1:0]    count;
    } t_sample_result;

    logic [DEB_W-1:0]    debounce_ms;
    logic [CHANNELS-1:0] active_level;

    t_db_state           db_state   [CHANNELS];
    logic [TIME_W-1:0]   db_start   [CHANNELS];
    logic                held       [CHANNELS];
    logic [COUNT_W-1:0]  press_cnt  [CHANNELS];
    t_event              latched_ev [CHANNELS];

    t_sample_result awaited_results[$];

    function automatic t_sample_result debounce_sample(
        input logic [CHANNELS-1:0] pins,
        input logic [TIME_W-1:0]   now,
        input logic [CHANNELS-1:0] rd,
        input logic [SEL_W-1:0]    sel
    );
        t_sample_result    res;
        logic              active;
        logic              expired;
        logic [TIME_W-1:0] elapsed;
        for (int c = 0; c < CHANNELS; c++) begin
            active  = (pins[c] == active_level[c]);
            elapsed = now - db_start[c];
            // timeout wins over the pin level
            expired = (elapsed >= TIME_W'(debounce_ms));
            case (db_state[c])
                DB_WAIT_PRESS: begin
                    if (expired) begin
                        held[c]       = 1'b1;
                        press_cnt[c]  = press_cnt[c] + 1'b1;
                        db_state[c]   = DB_HELD;
                        latched_ev[c] = EV_PRESSED;
                    end else if (!active) begin
                        db_state[c] = DB_IDLE;
                    end
                end
                DB_WAIT_RELEASE: begin
                    if (expired) begin
                        held[c]       = 1'b0;
                        db_state[c]   = DB_LET_GO;
                        latched_ev[c] = EV_RELEASED;
                    end else if (active) begin
                        db_state[c] = DB_IDLE;
                    end
                end
                DB_HELD: begin
                    if (!active) db_state[c] = DB_IDLE;
                end
                DB_LET_GO: begin
                    if (active) db_state[c] = DB_IDLE;
                end
                default: begin
                    db_start[c] = now;
                    db_state[c] = active ? DB_WAIT_PRESS : DB_WAIT_RELEASE;
                end
            endcase
        end
        for (int c = 0; c < CHANNELS; c++) begin
            res.pressed[c]      = held[c];
            res.codes[2*c +: 2] = latched_ev[c];
        end
        res.count = (sel < CHANNELS) ? press_cnt[sel] : '0;
        // read clears after the result has captured the event
        for (int c = 0; c < CHANNELS; c++) begin
            if (rd[c]) latched_ev[c] = EV_NONE;
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
        end
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_sample_result exp_r;
        if (!i_rst_n) begin
            debounce_ms  = DEBOUNCE_RESET;
            active_level = '0;
            for (int c = 0; c < CHANNELS; c++) begin
                db_state[c]   = DB_IDLE;
                db_start[c]   = '0;
                held[c]       = 1'b0;
                press_cnt[c]  = '0;
                latched_ev[c] = EV_NONE;
            end
            awaited_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == IDX_DEBOUNCE) debounce_ms = i_pwdata[DEB_W-1:0];
                else active_level = i_pwdata[CHANNELS-1:0];
            end
            if (i_in_valid && i_in_ready)
                awaited_results.push_back(debounce_sample(i_pin_levels, i_now_ms,
                                                          i_event_read_mask,
                                                          i_count_channel));
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result transfer with none expected, actual %0h/%0h/%0h",
                             $time, i_pressed_mask, i_event_codes, i_press_count);
                end else begin
                    exp_r = awaited_results.pop_front();
                    check_field("pressed_mask", exp_r.pressed, i_pressed_mask);
                    check_field("event_codes", exp_r.codes, i_event_codes);
                    check_field("press_count", exp_r.count, i_press_count);
                end
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for button_debounce_event_latch_core: clock, reset, APB setup, sample
// stimulus with bursty sender and stalling receiver, watchdog and verdict.
// Depends on bdel_pkg, bdel_if, the core and bdel_checker.
module tb_top;
    import bdel_pkg::*;

    localparam int CHANNELS   = 2;
    localparam int SEL_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PHASES     = 6;
    localparam int PHASE_ITEMS = 108;
    localparam int IDLE_LIMIT = 3000;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int pending;
    int idle_cycles;
    int burst_left;
    bit gaps_on;

    logic [15:0]         ready_pattern = 16'hFFFF;
    logic [3:0]          ready_pos = '0;
    logic [TIME_W-1:0]   cur_now;
    logic [CHANNELS-1:0] cur_pins;
    int                  deb_cur;

    bdel_in_if  #(.CHANNELS(CHANNELS)) in_ch ();
    bdel_out_if #(.CHANNELS(CHANNELS)) out_ch ();

    button_debounce_event_latch_core #(.CHANNELS(CHANNELS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bdel_checker #(.CHANNELS(CHANNELS), .SEL_W(SEL_W)) u_result_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_ch.valid),
        .i_in_ready        (in_ch.ready),
        .i_pin_levels      (in_ch.pin_levels),
        .i_now_ms          (in_ch.now_ms),
        .i_event_read_mask (in_ch.event_read_mask),
        .i_count_channel   (in_ch.count_channel),
        .i_out_valid       (out_ch.valid),
        .i_out_ready       (out_ch.ready),
        .i_pressed_mask    (out_ch.pressed_mask),
        .i_event_codes     (out_ch.event_codes),
        .i_press_count     (out_ch.press_count),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_pready          (pready),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver stalls follow a rotating per-phase pattern
    always @(negedge i_clk) begin
        out_ch.ready <= ready_pattern[ready_pos];
        ready_pos    <= ready_pos + 1'b1;
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL button_debounce_event_latch_core");
            $finish;
        end
    end

    task automatic send_item(input logic [CHANNELS-1:0] pins, input logic [TIME_W-1:0] now,
                             input logic [CHANNELS-1:0] rd, input logic [SEL_W-1:0] sel);
        int gap;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 20);
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left--;
        end
        in_ch.valid           <= 1'b1;
        in_ch.pin_levels      <= pins;
        in_ch.now_ms          <= now;
        in_ch.event_read_mask <= rd;
        in_ch.count_channel   <= sel;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_item();
        int                  pick;
        logic [TIME_W-1:0]   step;
        logic [CHANNELS-1:0] rd;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            step = $urandom_range(0, deb_cur / 8 + 1);
        end else if (pick < 70) begin
            // land right around the debounce boundary
            step = TIME_W'(deb_cur) + $urandom_range(0, 4);
            step = (step >= 2) ? step - 2 : '0;
        end else if (pick < 90) begin
            step = $urandom_range(0, 3);
        end else begin
            step = $urandom();
        end
        cur_now = cur_now + step;
        for (int c = 0; c < CHANNELS; c++)
            if ($urandom_range(0, 99) < 12) cur_pins[c] = ~cur_pins[c];
        rd = $urandom_range(0, 1) ? CHANNELS'($urandom_range(0, (1 << CHANNELS) - 1)) : '0;
        send_item(cur_pins, cur_now, rd, SEL_W'($urandom_range(0, CHANNELS - 1)));
    endtask

    task automatic apb_write(input logic idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        int          deb_tab  [PHASES];
        logic [1:0]  mask_tab [PHASES];
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        in_ch.valid           = 1'b0;
        in_ch.pin_levels      = '0;
        in_ch.now_ms          = '0;
        in_ch.event_read_mask = '0;
        in_ch.count_channel   = '0;
        out_ch.ready          = 1'b1;
        idle_cycles           = 0;
        burst_left            = 0;
        gaps_on               = 1'b1;
        deb_tab  = '{int'(DEBOUNCE_RESET), 0, 1, 65535, $urandom_range(2, 300), 7};
        mask_tab = '{2'd0, 2'd3, 2'd1, 2'd2, 2'($urandom_range(0, 3)), 2'd0};

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset settings, debounce 20 and both channels active low
        send_item(2'b11, 32'd0,  2'b00, 1'b0);
        send_item(2'b11, 32'd19, 2'b00, 1'b0);
        send_item(2'b11, 32'd20, 2'b00, 1'b1);   // both release events
        send_item(2'b11, 32'd21, 2'b11, 1'b0);
        send_item(2'b11, 32'd22, 2'b11, 1'b1);   // read with nothing latched
        send_item(2'b00, 32'd30, 2'b00, 1'b0);
        send_item(2'b00, 32'd31, 2'b00, 1'b0);
        send_item(2'b10, 32'd40, 2'b00, 1'b1);   // ch1 bounces back to idle
        send_item(2'b11, 32'd51, 2'b00, 1'b0);   // ch0 expires though pin let go
        send_item(2'b11, 32'd52, 2'b00, 1'b0);
        send_item(2'b11, 32'd53, 2'b00, 1'b0);
        send_item(2'b11, 32'd80, 2'b00, 1'b1);   // release overwrites unread press
        send_item(2'b11, 32'hFFFF_FFF0, 2'b11, 1'b0);
        send_item(2'b00, 32'hFFFF_FFF5, 2'b00, 1'b0);
        send_item(2'b00, 32'hFFFF_FFFA, 2'b00, 1'b1);
        send_item(2'b00, 32'h0000_000D, 2'b00, 1'b1);   // time wrap, one short
        send_item(2'b00, 32'h0000_000E, 2'b00, 1'b1);
        send_item(2'b00, 32'h8000_0000, 2'b01, 1'b0);
        send_item(2'b01, 32'h7FFF_FFFF, 2'b10, 1'b1);
        send_item(2'b10, 32'hFFFF_FFFF, 2'b11, 1'b0);

        cur_now  = 32'hFFFF_F000;
        cur_pins = 2'b11;
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                apb_write(IDX_DEBOUNCE, PDATA_W'(deb_tab[p]));
                apb_write(IDX_ACTIVE, PDATA_W'(mask_tab[p]));
                @(negedge i_clk);
            end
            deb_cur = deb_tab[p];
            gaps_on = (p != 2);
            ready_pattern = (p == 2) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
            for (int n = 0; n < PHASE_ITEMS; n++) random_item();
        end

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0)
            $display("PASS button_debounce_event_latch_core");
        else
            $display("FAIL button_debounce_event_latch_core");
        $finish;
    end

endmodule
